[rtl/core/bgc_pkg.sv]
`default_nettype none
package bgc_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int TICKS_WIDTH = 16;
  // Compare width covers both the count and the 16-bit limits.
  localparam int CMP_WIDTH   = (COUNT_WIDTH > TICKS_WIDTH) ? COUNT_WIDTH : TICKS_WIDTH;

  localparam int ADDR_WIDTH  = 4;
  localparam int DATA_WIDTH  = 32;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [TICKS_WIDTH-1:0] ticks_t;
  typedef logic [1:0]             reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_GAP     = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    EV_LONG   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2
  } gesture_t;

  localparam reg_idx_t REG_ACTIVE_HIGH = 2'd0;
  localparam reg_idx_t REG_LONG_TICKS  = 2'd1;
  localparam reg_idx_t REG_GAP_TICKS   = 2'd2;
  localparam reg_idx_t REG_EVENT_EN    = 2'd3;

  localparam logic   RST_ACTIVE_HIGH = 1'b0;
  localparam ticks_t RST_LONG_TICKS  = 16'd1000;
  localparam ticks_t RST_GAP_TICKS   = 16'd250;
  localparam logic [2:0] RST_EVENT_EN = 3'b111;

endpackage
`default_nettype wire

[rtl/core/bgc_in_if.sv]
`default_nettype none
interface bgc_in_if;
  logic valid;
  logic ready;
  logic level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface
`default_nettype wire

[rtl/core/bgc_out_if.sv]
`default_nettype none
interface bgc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] gesture;

  modport source (output valid, output gesture, input ready);
  modport sink   (input valid, input gesture, output ready);
endinterface
`default_nettype wire

[rtl/core/button_gesture_classifier.sv]
`default_nettype none
// Button gesture classifier. Each input item is one sampled button level; the block tracks
// press and gap durations and emits at most one result item per input item: long press (0),
// single click (1) or double click (2), each gated by its bit in event_enable. An item is
// accepted every clock cycle: the phase/count update is a single compare-and-increment stage,
// and a two-entry output buffer (result register plus skid register) keeps the input side
// running while a result waits to be taken; in_ch.ready drops only when both entries are full.
// Registers sit on the APB port at byte addresses 0x0 active_high, 0x4 long_press_ticks,
// 0x8 double_gap_ticks and 0xC event_enable; write them only while the block is idle.
module button_gesture_classifier (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  bgc_in_if.sink                                 in_ch,
  bgc_out_if.source                              out_ch,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [bgc_pkg::ADDR_WIDTH-1:0]    cfg_paddr,
  input  wire logic [bgc_pkg::DATA_WIDTH-1:0]    cfg_pwdata,
  output logic      [bgc_pkg::DATA_WIDTH-1:0]    cfg_prdata,
  output logic                                   cfg_pready
);

  localparam bgc_pkg::count_t COUNT_MAX = {bgc_pkg::COUNT_WIDTH{1'b1}};

  // Configuration registers.
  logic             active_high_r;
  bgc_pkg::ticks_t  long_ticks_r;
  bgc_pkg::ticks_t  gap_ticks_r;
  logic [2:0]       event_en_r;

  bgc_pkg::reg_idx_t cfg_idx;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_high_r <= bgc_pkg::RST_ACTIVE_HIGH;
      long_ticks_r  <= bgc_pkg::RST_LONG_TICKS;
      gap_ticks_r   <= bgc_pkg::RST_GAP_TICKS;
      event_en_r    <= bgc_pkg::RST_EVENT_EN;
    end else if (cfg_wr) begin
      case (cfg_idx)
        bgc_pkg::REG_ACTIVE_HIGH: active_high_r <= cfg_pwdata[0];
        bgc_pkg::REG_LONG_TICKS:  long_ticks_r  <= cfg_pwdata[15:0];
        bgc_pkg::REG_GAP_TICKS:   gap_ticks_r   <= cfg_pwdata[15:0];
        bgc_pkg::REG_EVENT_EN:    event_en_r    <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      bgc_pkg::REG_ACTIVE_HIGH: cfg_prdata = {31'd0, active_high_r};
      bgc_pkg::REG_LONG_TICKS:  cfg_prdata = {16'd0, long_ticks_r};
      bgc_pkg::REG_GAP_TICKS:   cfg_prdata = {16'd0, gap_ticks_r};
      bgc_pkg::REG_EVENT_EN:    cfg_prdata = {29'd0, event_en_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  // Classifier state.
  bgc_pkg::phase_t  phase_r, phase_nxt;
  bgc_pkg::count_t  count_r, count_nxt;

  logic                         accept;
  logic                         pressed;
  bgc_pkg::count_t              count_inc;
  logic [bgc_pkg::CMP_WIDTH-1:0] count_cmp;
  logic [bgc_pkg::CMP_WIDTH-1:0] long_cmp;
  logic [bgc_pkg::CMP_WIDTH-1:0] gap_cmp;
  logic                         ev_fire;
  bgc_pkg::gesture_t            ev_code;
  logic                         push;

  assign accept    = in_ch.valid && in_ch.ready;
  assign pressed   = (in_ch.level == active_high_r);
  assign count_inc = (count_r == COUNT_MAX) ? COUNT_MAX : count_r + 1'b1;
  assign count_cmp = bgc_pkg::CMP_WIDTH'(count_inc);
  assign long_cmp  = bgc_pkg::CMP_WIDTH'(long_ticks_r);
  assign gap_cmp   = bgc_pkg::CMP_WIDTH'(gap_ticks_r);

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    ev_fire   = 1'b0;
    ev_code   = bgc_pkg::EV_LONG;
    case (phase_r)
      bgc_pkg::PH_PRESSED: begin
        count_nxt = count_inc;
        if (count_cmp == long_cmp) begin
          ev_fire = 1'b1;
          ev_code = bgc_pkg::EV_LONG;
        end else if (!pressed) begin
          if (gap_ticks_r == '0) begin
            ev_fire = 1'b1;
            ev_code = bgc_pkg::EV_SINGLE;
          end else begin
            phase_nxt = bgc_pkg::PH_GAP;
            count_nxt = '0;
          end
        end
      end
      bgc_pkg::PH_GAP: begin
        count_nxt = count_inc;
        if (count_cmp == gap_cmp) begin
          ev_fire = 1'b1;
          ev_code = bgc_pkg::EV_SINGLE;
        end else if (pressed) begin
          ev_fire = 1'b1;
          ev_code = bgc_pkg::EV_DOUBLE;
        end
      end
      default: begin
        phase_nxt = bgc_pkg::PH_IDLE;
        count_nxt = '0;
        if (pressed) begin
          if (long_ticks_r == '0) begin
            ev_fire = 1'b1;
            ev_code = bgc_pkg::EV_LONG;
          end else begin
            phase_nxt = bgc_pkg::PH_PRESSED;
          end
        end
      end
    endcase
    // Every event, enabled or not, sends the classifier back to idle.
    if (ev_fire) begin
      phase_nxt = bgc_pkg::PH_IDLE;
      count_nxt = '0;
    end
  end

  assign push = accept && ev_fire && event_en_r[ev_code];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bgc_pkg::PH_IDLE;
      count_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  // Two-entry output buffer: head register drives the port, skid catches one more item.
  logic              head_valid_r, skid_valid_r;
  bgc_pkg::gesture_t head_code_r, skid_code_r;
  logic              pop;

  assign pop            = out_ch.valid && out_ch.ready;
  assign out_ch.valid   = head_valid_r;
  assign out_ch.gesture = head_code_r;
  assign in_ch.ready    = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_r) begin
          head_valid_r <= 1'b1;
          skid_valid_r <= push;
        end else begin
          head_valid_r <= push;
        end
      end else if (push) begin
        if (head_valid_r) begin
          skid_valid_r <= 1'b1;
        end else begin
          head_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        head_code_r <= skid_code_r;
        if (push) begin
          skid_code_r <= ev_code;
        end
      end else if (push) begin
        head_code_r <= ev_code;
      end
    end else if (push) begin
      if (head_valid_r) begin
        skid_code_r <= ev_code;
      end else begin
        head_code_r <= ev_code;
      end
    end
  end

endmodule
`default_nettype wire

[tb/gesture_checker.sv]
`timescale 1ns / 100ps

module gesture_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  bgc_in_if                              in_ch,
  bgc_out_if                             out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [bgc_pkg::ADDR_WIDTH-1:0] cfg_paddr,
  input  logic [bgc_pkg::DATA_WIDTH-1:0] cfg_pwdata,
  input  logic                           cfg_pready,
  output int                             fail_count,
  output int                             pending,
  output int                             checked
);

  // Own copy of the register file and of the press/gap tracker.
  logic              act_level;
  bgc_pkg::ticks_t   long_limit;
  bgc_pkg::ticks_t   gap_limit;
  logic [2:0]        enabled;
  bgc_pkg::phase_t   ph;
  bgc_pkg::count_t   cnt;

  bgc_pkg::gesture_t gestures_due[$];
  bgc_pkg::gesture_t want;
  int                errs = 0;
  int                checked_n = 0;

  task automatic report(input string msg);
    errs++;
    if (errs <= 40) begin
      $display("%0t ERROR: %s", $realtime, msg);
    end
  endtask

  task automatic classify_level(input logic lv);
    logic              pressed;
    logic              fired;
    bgc_pkg::gesture_t g;
    pressed = (lv == act_level);
    fired = 1'b0;
    g = bgc_pkg::EV_LONG;
    case (ph)
      bgc_pkg::PH_PRESSED: begin
        if (cnt != '1) cnt = cnt + 1'b1;
        if (cnt == long_limit) begin
          fired = 1'b1;
          g = bgc_pkg::EV_LONG;
        end else if (!pressed) begin
          if (gap_limit == '0) begin
            fired = 1'b1;
            g = bgc_pkg::EV_SINGLE;
          end else begin
            ph = bgc_pkg::PH_GAP;
            cnt = '0;
          end
        end
      end
      bgc_pkg::PH_GAP: begin
        if (cnt != '1) cnt = cnt + 1'b1;
        if (cnt == gap_limit) begin
          fired = 1'b1;
          g = bgc_pkg::EV_SINGLE;
        end else if (pressed) begin
          fired = 1'b1;
          g = bgc_pkg::EV_DOUBLE;
        end
      end
      default: begin
        ph = bgc_pkg::PH_IDLE;
        cnt = '0;
        if (pressed) begin
          // A zero hold time reports the long press on the first pressed sample.
          if (long_limit == '0) begin
            fired = 1'b1;
            g = bgc_pkg::EV_LONG;
          end else begin
            ph = bgc_pkg::PH_PRESSED;
          end
        end
      end
    endcase
    if (fired) begin
      ph = bgc_pkg::PH_IDLE;
      cnt = '0;
      if (enabled[g]) gestures_due.push_back(g);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      act_level = bgc_pkg::RST_ACTIVE_HIGH;
      long_limit = bgc_pkg::RST_LONG_TICKS;
      gap_limit = bgc_pkg::RST_GAP_TICKS;
      enabled = bgc_pkg::RST_EVENT_EN;
      ph = bgc_pkg::PH_IDLE;
      cnt = '0;
      gestures_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[bgc_pkg::ADDR_WIDTH-1:2])
          bgc_pkg::REG_ACTIVE_HIGH: act_level = cfg_pwdata[0];
          bgc_pkg::REG_LONG_TICKS:  long_limit = cfg_pwdata[15:0];
          bgc_pkg::REG_GAP_TICKS:   gap_limit = cfg_pwdata[15:0];
          bgc_pkg::REG_EVENT_EN:    enabled = cfg_pwdata[2:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) classify_level(in_ch.level);
      if (out_ch.valid && out_ch.ready) begin
        if (gestures_due.size() == 0) begin
          report($sformatf("gesture %0d arrived with none expected", out_ch.gesture));
        end else begin
          want = gestures_due.pop_front();
          checked_n++;
          if (out_ch.gesture !== want) begin
            report($sformatf("gesture %0d, expected %0d", out_ch.gesture, want));
          end
        end
      end
    end
    pending <= gestures_due.size();
    fail_count <= errs;
    checked <= checked_n;
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT     = 200_000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_OFF_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n;

  bgc_in_if  in_ch();
  bgc_out_if out_ch();

  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [bgc_pkg::ADDR_WIDTH-1:0] cfg_paddr;
  logic [bgc_pkg::DATA_WIDTH-1:0] cfg_pwdata;
  logic [bgc_pkg::DATA_WIDTH-1:0] cfg_prdata;
  logic                           cfg_pready;

  int fail_count;
  int pending;
  int checked;

  // Mirror of the level and limit registers as last written, used to shape the stimulus.
  logic       act_lvl = bgc_pkg::RST_ACTIVE_HIGH;
  int         long_t = int'(bgc_pkg::RST_LONG_TICKS);
  int         gap_t = int'(bgc_pkg::RST_GAP_TICKS);

  int   items_sent = 0;
  int   settings_run = 0;
  int   burst_left = 0;
  bit   gaps_on = 1'b1;
  int   cycle_cnt = 0;

  // Toggled by the stimulus to ask the receiver for one long hold-off.
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int   stall_left = 0;
  int   rx_mode = 0;
  int   rx_mode_left = 0;

  always #5 clk = ~clk;

  button_gesture_classifier i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  gesture_checker u_gesture_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d gestures outstanding", cycle_cnt, pending);
      $display("button_gesture_classifier test failed");
      $finish;
    end
  end

  // Receiver: switches between random stall patterns, and holds off
  // for a long stretch once when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      stall_left <= HOLD_OFF_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_mode_left <= $urandom_range(20, 300);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= (rx_mode_left % 4 != 0);
      endcase
    end
  end

  task automatic cfg_write(input bgc_pkg::reg_idx_t idx,
                           input logic [bgc_pkg::DATA_WIDTH-1:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic a, input int l, input int g, input logic [2:0] e);
    cfg_write(bgc_pkg::REG_ACTIVE_HIGH, bgc_pkg::DATA_WIDTH'(a));
    cfg_write(bgc_pkg::REG_LONG_TICKS, bgc_pkg::DATA_WIDTH'(l));
    cfg_write(bgc_pkg::REG_GAP_TICKS, bgc_pkg::DATA_WIDTH'(g));
    cfg_write(bgc_pkg::REG_EVENT_EN, bgc_pkg::DATA_WIDTH'(e));
    act_lvl = a;
    long_t = l;
    gap_t = g;
    settings_run++;
  endtask

  task automatic send_level(input logic lv);
    int pause;
    if (gaps_on && burst_left == 0) begin
      pause = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (pause) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid <= 1'b1;
    in_ch.level <= lv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    items_sent++;
  endtask

  task automatic hold(input logic lv, input int n);
    repeat (n) send_level(lv);
  endtask

  task automatic play_levels(input logic [31:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) send_level(bits[i]);
  endtask

  // Released samples for longer than any gap bring the tracker back to idle.
  task automatic release_to_idle();
    hold(~act_lvl, gap_t + 2);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Durations cluster on the limit itself, one either side, or a short press.
  function automatic int pick_len(input int limit);
    int len;
    case ($urandom_range(0, 3))
      0: len = $urandom_range(1, 6);
      1: len = limit - 1;
      2: len = limit;
      default: len = limit + 1;
    endcase
    if (len < 1) len = 1;
    return len;
  endfunction

  task automatic random_gesture();
    int   kind;
    int   n;
    logic pl;
    logic rl;
    pl = act_lvl;
    rl = ~act_lvl;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      n = $urandom_range(1, 12);
      repeat (n) send_level(1'($urandom_range(0, 1)));
    end else if (kind < 4) begin
      // Holding past one or two long-press times repeats the long press.
      hold(pl, (long_t + 1) * $urandom_range(1, 2) + $urandom_range(0, 1));
      hold(rl, $urandom_range(1, 3));
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        hold(pl, pick_len(long_t));
        hold(rl, pick_len(gap_t));
      end
    end
  endtask

  task automatic run_phase(input logic a, input int l, input int g, input logic [2:0] e,
                           input int budget, input bit squeeze);
    int start;
    apply_setting(a, l, g, e);
    gaps_on = ($urandom_range(0, 3) != 0);
    if (squeeze) begin
      hold_req <= ~hold_req;
      hold(act_lvl, 10);
    end
    start = items_sent;
    while (items_sent - start < budget) random_gesture();
    release_to_idle();
    drain();
  endtask

  initial begin
    logic a;
    in_ch.valid <= 1'b0;
    in_ch.level <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: a long press at the default hold time, a single click once
    // the default gap runs out, then a double click.
    hold(act_lvl, long_t + 1);
    hold(~act_lvl, 2);
    hold(act_lvl, 3);
    hold(~act_lvl, gap_t + 1);
    hold(act_lvl, 2);
    hold(~act_lvl, 5);
    hold(act_lvl, 1);
    hold(~act_lvl, 2);
    drain();

    // Directed: long press, single click and double click with short limits.
    apply_setting(1'b1, 3, 2, 3'b111);
    play_levels(13'b1111010001010, 13);
    drain();
    // Zero hold time: every pressed sample is a long press, active low.
    apply_setting(1'b0, 0, 5, 3'b111);
    play_levels(4'b0010, 4);
    drain();
    // Zero gap time with single clicks masked off, then a long press.
    apply_setting(1'b1, 2, 0, 3'b101);
    play_levels(6'b101110, 6);
    drain();

    run_phase(1'b1, 1, 1, 3'b111, 30, 1'b0);
    run_phase(1'b0, 0, 0, 3'b111, 30, 1'b1);
    run_phase(1'($urandom_range(0, 1)), $urandom_range(2, 12), $urandom_range(2, 12),
              3'b000, 30, 1'b0);
    repeat (8) begin
      run_phase(1'($urandom_range(0, 1)), $urandom_range(0, 24), $urandom_range(0, 24),
                3'($urandom_range(0, 7)), 30, 1'b0);
    end

    // Full-scale limits: a double click well inside the longest gap.
    a = 1'($urandom_range(0, 1));
    apply_setting(a, 65535, 65535, 3'b111);
    gaps_on = 1'b0;
    hold(a, 3);
    hold(~a, 7);
    hold(a, 1);
    hold(~a, 1);
    drain();

    $display("Run covered %0d input items at the reset values and %0d written settings,",
             items_sent, settings_run);
    $display("with zero, one and full-scale limits, all masks and a long receiver stall;");
    $display("%0d gestures checked.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("button_gesture_classifier test passed");
    end else begin
      $display("button_gesture_classifier test failed");
    end
    $finish;
  end

endmodule

[button_gesture_classifier.f]
rtl/core/bgc_pkg.sv
rtl/core/bgc_in_if.sv
rtl/core/bgc_out_if.sv
rtl/core/button_gesture_classifier.sv
tb/gesture_checker.sv
tb/testbench.sv
